[sv/sba_pkg.sv]
// Package for the bitmap slot allocator: shared constants, codes and payload types.
// Used by every module of the block but sba_ram; depends on nothing else.
package sba_pkg;

  // Default sizes of the slot pool.
  localparam int unsigned WORD_BITS_DEF = 64;
  localparam int unsigned MAX_WORDS_DEF = 4;
  localparam int unsigned ID_SHIFT_DEF  = 8;

  // Fixed field widths.
  localparam int unsigned HANDLE_W   = 16;
  localparam int unsigned BASE_W     = 8;
  localparam int unsigned POOL_W     = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 1;

  // Reset value of the pool size register.
  localparam logic [POOL_W-1:0] POOL_WORDS_RST = POOL_W'(4);

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  // Request kinds.
  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_BASE  = 1'b0,
    CFG_POOL_WORDS = 1'b1
  } cfg_idx_e;

  // Operations handed from the front to the back.
  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_BAD    = 2'd2,
    OP_NOSLOT = 2'd3
  } op_e;

  // Input request payload.
  typedef struct packed {
    req_type_e           req_type;
    logic [HANDLE_W-1:0] handle;
  } req_t;

  // Result payload.
  typedef struct packed {
    logic [HANDLE_W-1:0] granted_handle;
    status_e             status;
  } res_t;

  // One entry of the queue between front and back.
  typedef struct packed {
    op_e                 op;
    logic [HANDLE_W-1:0] id;
  } entry_t;

  // Queue fill status.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[sv/sba_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependency.
module sba_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/sba_queue.sv]
// Two-entry queue that decouples the request front from the execution back.
// Depends on sba_pkg for the entry and status types.
module sba_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  sba_pkg::entry_t       entry_i,
  input  logic                  pop_i,
  output sba_pkg::entry_t       entry_o,
  output sba_pkg::queue_status_t status_o
);

  sba_pkg::entry_t entries_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= entry_i;
    end
  end

  assign entry_o        = entries_q[rd_ptr_q];
  assign status_o.full  = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);

endmodule

[sv/sba_front.sv]
// Request front: accepts requests and classifies them into queue operations.
// Depends on sba_pkg for the request, entry and status types.
module sba_front #(
  parameter int unsigned WORD_BITS = sba_pkg::WORD_BITS_DEF,
  parameter int unsigned MAX_WORDS = sba_pkg::MAX_WORDS_DEF,
  parameter int unsigned ID_SHIFT  = sba_pkg::ID_SHIFT_DEF,
  localparam int unsigned CW       = $clog2(MAX_WORDS + 1)
) (
  input  logic                   start,
  input  sba_pkg::req_t          req_i,
  input  sba_pkg::queue_status_t qstat_i,
  input  logic [CW-1:0]          active_words_i,
  output logic                   busy,
  output logic                   push_o,
  output sba_pkg::entry_t        entry_o
);

  logic [sba_pkg::HANDLE_W-1:0] slot_id;
  logic                         out_of_pool;

  // The request is taken whenever the queue has room.
  assign busy   = qstat_i.full;
  assign push_o = start && !qstat_i.full;

  // Recover the slot id and check it against the slot count in use.
  assign slot_id     = sba_pkg::HANDLE_W'(req_i.handle >> ID_SHIFT);
  assign out_of_pool = (32'(slot_id) >= 32'(active_words_i) * WORD_BITS);

  // Classify: an empty pool or a bad handle is settled without touching the map.
  always_comb begin
    entry_o.id = slot_id;
    unique case (req_i.req_type)
      sba_pkg::REQ_ALLOC: begin
        entry_o.op = (active_words_i == '0) ? sba_pkg::OP_NOSLOT : sba_pkg::OP_ALLOC;
      end
      sba_pkg::REQ_FREE: begin
        entry_o.op = out_of_pool ? sba_pkg::OP_BAD : sba_pkg::OP_FREE;
      end
      default: begin
        entry_o.op = sba_pkg::OP_BAD;
      end
    endcase
  end

endmodule

[sv/sba_back.sv]
// Execution back: scans and updates the used-slot bitmap, one word per cycle.
// Depends on sba_pkg and on sba_ram for the bitmap store.
module sba_back #(
  parameter int unsigned WORD_BITS = sba_pkg::WORD_BITS_DEF,
  parameter int unsigned MAX_WORDS = sba_pkg::MAX_WORDS_DEF,
  parameter int unsigned ID_SHIFT  = sba_pkg::ID_SHIFT_DEF,
  localparam int unsigned CW       = $clog2(MAX_WORDS + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sba_pkg::entry_t           entry_i,
  input  sba_pkg::queue_status_t    qstat_i,
  input  logic [CW-1:0]             active_words_i,
  input  logic [sba_pkg::BASE_W-1:0] node_base_i,
  output logic                      pop_o,
  output logic                      done_o,
  output sba_pkg::res_t             result_o
);

  localparam int unsigned AW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned BW  = $clog2(WORD_BITS);
  localparam int unsigned IDW = $clog2(MAX_WORDS * WORD_BITS);
  localparam int unsigned HW  = IDW + ID_SHIFT + sba_pkg::HANDLE_W;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_SEEK
  } state_e;

  state_e                 state_q, state_d;
  logic [AW-1:0]          w_q, w_d;
  logic [IDW-1:0]         rem_q, rem_d;
  logic                   done_q, done_d;
  sba_pkg::res_t          res_q, res_d;

  logic [MAX_WORDS-1:0]   valid_q;
  logic                   rvalid_q;

  logic [AW-1:0]          rd_addr;
  logic                   we;
  logic [WORD_BITS-1:0]   wdata;
  logic [WORD_BITS-1:0]   rdata;
  logic [WORD_BITS-1:0]   word;
  logic [WORD_BITS-1:0]   lowest_zero;
  logic                   all_used;
  logic [BW-1:0]          bit_idx;
  logic                   last_word;
  logic [IDW-1:0]         slot_id;
  logic [HW-1:0]          shifted_id;
  logic [sba_pkg::HANDLE_W-1:0] alloc_handle;
  logic                   seek_hit;
  logic [WORD_BITS-1:0]   clr_mask;
  logic [AW-1:0]          w_next;

  // Bitmap store.
  sba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAX_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (w_q),
    .wdata_i (wdata),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // A word never written since reset reads as all free.
  assign word = rvalid_q ? rdata : '0;

  // Lowest clear bit as a one-hot mask, then its index.
  assign lowest_zero = ~word & (word + WORD_BITS'(1));
  assign all_used    = &word;

  always_comb begin
    bit_idx = '0;
    for (int i = 0; i < int'(WORD_BITS); i++) begin
      if (lowest_zero[i]) begin
        bit_idx = bit_idx | BW'(i);
      end
    end
  end

  // Handle of the slot found in the current word.
  assign last_word    = ((32'(w_q) + 32'd1) == 32'(active_words_i));
  assign w_next       = AW'(32'(w_q) + 32'd1);
  assign slot_id      = IDW'(32'(w_q) * WORD_BITS + 32'(bit_idx));
  assign shifted_id   = HW'(slot_id) << ID_SHIFT;
  assign alloc_handle = shifted_id[sba_pkg::HANDLE_W-1:0]
                        | sba_pkg::HANDLE_W'(node_base_i);

  // On a free the remaining offset falls into the current word once below the word size.
  assign seek_hit = (32'(rem_q) < WORD_BITS);
  assign clr_mask = ~(WORD_BITS'(1) << rem_q[BW-1:0]);

  // Sequencer for one operation at a time.
  always_comb begin
    state_d = state_q;
    w_d     = w_q;
    rem_d   = rem_q;
    done_d  = 1'b0;
    res_d   = res_q;
    pop_o   = 1'b0;
    rd_addr = w_q;
    we      = 1'b0;
    wdata   = word;
    unique case (state_q)
      B_IDLE: begin
        rd_addr = '0;
        if (!qstat_i.empty) begin
          pop_o = 1'b1;
          w_d   = '0;
          rem_d = IDW'(entry_i.id);
          unique case (entry_i.op)
            sba_pkg::OP_ALLOC: begin
              state_d = B_SCAN;
            end
            sba_pkg::OP_FREE: begin
              state_d = B_SEEK;
            end
            sba_pkg::OP_BAD: begin
              done_d               = 1'b1;
              res_d.granted_handle = '0;
              res_d.status         = sba_pkg::ST_BAD;
            end
            sba_pkg::OP_NOSLOT: begin
              done_d               = 1'b1;
              res_d.granted_handle = '0;
              res_d.status         = sba_pkg::ST_FULL;
            end
            default: begin
              state_d = B_IDLE;
            end
          endcase
        end
      end
      B_SCAN: begin
        if (!all_used) begin
          we                   = 1'b1;
          wdata                = word | lowest_zero;
          done_d               = 1'b1;
          res_d.granted_handle = alloc_handle;
          res_d.status         = sba_pkg::ST_OK;
          state_d              = B_IDLE;
        end else if (last_word) begin
          done_d               = 1'b1;
          res_d.granted_handle = '0;
          res_d.status         = sba_pkg::ST_FULL;
          state_d              = B_IDLE;
        end else begin
          w_d     = w_next;
          rd_addr = w_next;
        end
      end
      B_SEEK: begin
        if (seek_hit) begin
          we                   = 1'b1;
          wdata                = word & clr_mask;
          done_d               = 1'b1;
          res_d.granted_handle = '0;
          res_d.status         = sba_pkg::ST_OK;
          state_d              = B_IDLE;
        end else begin
          w_d     = w_next;
          rd_addr = w_next;
          rem_d   = IDW'(32'(rem_q) - WORD_BITS);
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  // State and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      w_q     <= '0;
      rem_q   <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      w_q     <= w_d;
      rem_q   <= rem_d;
      done_q  <= done_d;
      res_q   <= res_d;
    end
  end

  // Per-word written flags: reset frees the whole map at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we) begin
        valid_q[w_q] <= 1'b1;
      end
      rvalid_q <= valid_q[rd_addr];
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

[sv/bitmap_slot_allocator_core.sv]
// Bitmap slot allocator: first-fit allocate and free over a used-slot bitmap.
// Requests pass a two-entry queue to the back end, which settles a bad handle or an
// empty pool without reading the bitmap, scans the bitmap from word 0 on an allocate,
// steps to the word of the slot on a free, and registers the result. The back end takes
// one request at a time, while the queue takes new ones until it is full; the bitmap is
// read one word per cycle. Results cannot be stalled.
// Reset is asynchronous: it frees every slot at once and sets base 0, pool 4 words.
module bitmap_slot_allocator_core #(
  parameter int unsigned WORD_BITS = sba_pkg::WORD_BITS_DEF,
  parameter int unsigned MAX_WORDS = sba_pkg::MAX_WORDS_DEF,
  parameter int unsigned ID_SHIFT  = sba_pkg::ID_SHIFT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  sba_pkg::req_t                 req_i,
  output logic                          busy,
  output logic                          done_o,
  output sba_pkg::res_t                 result_o,
  input  logic                          cfg_we_i,
  input  logic [sba_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sba_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_WORDS + 1);

  logic [sba_pkg::BASE_W-1:0] node_base_q;
  logic [sba_pkg::POOL_W-1:0] pool_words_q;
  logic [CW-1:0]              active_words;

  logic                   push;
  logic                   pop;
  sba_pkg::entry_t        push_entry;
  sba_pkg::entry_t        head_entry;
  sba_pkg::queue_status_t qstat;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_base_q  <= '0;
      pool_words_q <= sba_pkg::POOL_WORDS_RST;
    end else if (cfg_we_i) begin
      unique case (sba_pkg::cfg_idx_e'(cfg_idx_i))
        sba_pkg::CFG_NODE_BASE: begin
          node_base_q <= cfg_data_i[sba_pkg::BASE_W-1:0];
        end
        sba_pkg::CFG_POOL_WORDS: begin
          pool_words_q <= cfg_data_i[sba_pkg::POOL_W-1:0];
        end
        default: begin
          node_base_q <= node_base_q;
        end
      endcase
    end
  end

  // Pool size saturates at the number of words provided.
  assign active_words = (32'(pool_words_q) > MAX_WORDS) ? CW'(MAX_WORDS)
                                                        : CW'(pool_words_q);

  sba_front #(
    .WORD_BITS (WORD_BITS),
    .MAX_WORDS (MAX_WORDS),
    .ID_SHIFT  (ID_SHIFT)
  ) u_front (
    .start          (start),
    .req_i          (req_i),
    .qstat_i        (qstat),
    .active_words_i (active_words),
    .busy           (busy),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  sba_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (head_entry),
    .status_o (qstat)
  );

  sba_back #(
    .WORD_BITS (WORD_BITS),
    .MAX_WORDS (MAX_WORDS),
    .ID_SHIFT  (ID_SHIFT)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .entry_i        (head_entry),
    .qstat_i        (qstat),
    .active_words_i (active_words),
    .node_base_i    (node_base_q),
    .pop_o          (pop),
    .done_o         (done_o),
    .result_o       (result_o)
  );

endmodule

[sv/sba_checker.sv]
// Port-level checker for the bitmap slot allocator, bound to the top level.
// Depends on sba_pkg and attaches to bitmap_slot_allocator_core.
module sba_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input sba_pkg::res_t result_o,
  input logic          cfg_we_i
);

  logic       accept;
  logic [1:0] pending_q, pending_d;

  assign accept = start && !busy;

  // Count of accepted requests whose result is still due.
  always_comb begin
    pending_d = pending_q;
    if (accept && !done_o) begin
      pending_d = pending_q + 2'd1;
    end else if (done_o && !accept) begin
      pending_d = pending_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 2'd0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // A failed result never carries a handle; free results carry none either but are not checked.
  a_fail_no_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (result_o.status != sba_pkg::ST_OK) |-> (result_o.granted_handle == '0))
    else $error("failed result carries a handle");

  // No result appears without an outstanding request.
  a_done_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pending_q != 2'd0))
    else $error("result without an outstanding request");

  // Busy is raised only once requests have piled up.
  a_busy_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> (pending_q >= 2'd2))
    else $error("busy without a backlog");

  // A request into an empty block passes the queue and the result register before it is answered.
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (pending_q == 2'd0) |=> !done_o)
    else $error("result came too early");

  // Configuration is only written while no request is outstanding.
  a_cfg_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> (pending_q == 2'd0))
    else $error("configuration written with requests in flight");

endmodule

bind bitmap_slot_allocator_core sba_checker u_sba_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .result_o   (result_o),
  .cfg_we_i   (cfg_we_i)
);

[dv/bitmap_slot_allocator_core_tb.sv]
// Self-checking testbench for bitmap_slot_allocator_core: allocate and free requests
// are checked against a bitmap predictor. Depends on sba_pkg and the core only.
`timescale 1ns / 100ps

module bitmap_slot_allocator_core_tb;

  localparam int unsigned WORD_BITS   = sba_pkg::WORD_BITS_DEF;
  localparam int unsigned MAX_WORDS   = sba_pkg::MAX_WORDS_DEF;
  localparam int unsigned ID_SHIFT    = sba_pkg::ID_SHIFT_DEF;
  localparam int unsigned HANDLE_W    = sba_pkg::HANDLE_W;
  localparam int unsigned BASE_W      = sba_pkg::BASE_W;
  localparam int unsigned POOL_W      = sba_pkg::POOL_W;
  localparam int unsigned CFG_DATA_W  = sba_pkg::CFG_DATA_W;
  localparam int unsigned CFG_IDX_W   = sba_pkg::CFG_IDX_W;
  localparam int unsigned SETTLE_CYC  = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef logic [MAX_WORDS-1:0][WORD_BITS-1:0] slot_map_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  sba_pkg::req_t         req_i;
  logic                  busy;
  logic                  done_o;
  sba_pkg::res_t         result_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Shadow of the configuration registers and two copies of the slot bitmap:
  // one follows requests as they are queued, the other as the block accepts them.
  logic [BASE_W-1:0] cfg_base;
  logic [POOL_W-1:0] cfg_words;
  slot_map_t         queued_map;
  slot_map_t         slot_map;

  sba_pkg::req_t request_q[$];
  sba_pkg::res_t grant_expect_q[$];
  sba_pkg::res_t grant_exp;
  int unsigned   issued_count = 0;
  int unsigned   result_count = 0;
  int unsigned   fail_count   = 0;
  int unsigned   cycle_count  = 0;
  int unsigned   idle_left    = 0;
  bit            quiet_mode   = 1'b0;

  bitmap_slot_allocator_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_i      (req_i),
    .busy       (busy),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Clock with a 4 ns period.
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Number of bitmap words in use; larger settings saturate.
  function automatic int unsigned active_words(input logic [POOL_W-1:0] words);
    return (words > MAX_WORDS) ? MAX_WORDS : int'(words);
  endfunction

  // First-fit allocate or free on the given bitmap, returning the expected result.
  function automatic sba_pkg::res_t predict_request(inout slot_map_t map,
                                                    input logic [BASE_W-1:0] base,
                                                    input logic [POOL_W-1:0] words,
                                                    input sba_pkg::req_t req);
    sba_pkg::res_t res;
    int unsigned   n;
    int unsigned   id;
    bit            found;
    res.granted_handle = '0;
    res.status         = sba_pkg::ST_OK;
    n     = active_words(words);
    found = 1'b0;
    if (req.req_type == sba_pkg::REQ_ALLOC) begin
      res.status = sba_pkg::ST_FULL;
      for (int w = 0; w < MAX_WORDS; w++) begin
        // Full words are skipped; the lowest clear bit of the first other word wins.
        if (!found && w < n && map[w] != '1) begin
          for (int b = 0; b < WORD_BITS; b++) begin
            if (!found && !map[w][b]) begin
              found              = 1'b1;
              map[w][b]          = 1'b1;
              id                 = w * WORD_BITS + b;
              res.granted_handle = HANDLE_W'((id << ID_SHIFT) | base);
              res.status         = sba_pkg::ST_OK;
            end
          end
        end
      end
    end else begin
      id = req.handle >> ID_SHIFT;
      if (id >= n * WORD_BITS) begin
        res.status = sba_pkg::ST_BAD;
      end else begin
        map[id / WORD_BITS][id % WORD_BITS] = 1'b0;
      end
    end
    return res;
  endfunction

  // Mismatches are printed on one line and counted.
  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  // Queues one request and advances the queued-side bitmap.
  task automatic queue_request(input sba_pkg::req_type_e kind,
                               input logic [HANDLE_W-1:0] handle);
    sba_pkg::req_t req;
    req.req_type = kind;
    req.handle   = handle;
    void'(predict_request(queued_map, cfg_base, cfg_words, req));
    request_q.push_back(req);
  endtask

  // Random request: mostly allocates or frees of slots in use, some random handles.
  task automatic queue_random(input int unsigned alloc_pct);
    int unsigned slots;
    int unsigned probe;
    int unsigned id;
    bit          hit;
    logic [HANDLE_W-1:0] handle;
    handle = HANDLE_W'($urandom);
    hit    = 1'b0;
    if ($urandom_range(0, 99) < alloc_pct) begin
      queue_request(sba_pkg::REQ_ALLOC, handle);
    end else begin
      slots = active_words(cfg_words) * WORD_BITS;
      if (slots != 0 && $urandom_range(0, 9) < 7) begin
        probe = $urandom_range(0, slots - 1);
        for (int k = 0; k < slots; k++) begin
          id = (probe + k) % slots;
          if (!hit && queued_map[id / WORD_BITS][id % WORD_BITS]) begin
            hit    = 1'b1;
            handle = HANDLE_W'((id << ID_SHIFT) | $urandom_range(0, (1 << ID_SHIFT) - 1));
          end
        end
      end
      queue_request(sba_pkg::REQ_FREE, handle);
    end
  endtask

  // Waits until every queued request has been answered and the block has settled.
  task automatic wait_idle();
    while (request_q.size() != 0 || issued_count != result_count) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(input sba_pkg::cfg_idx_e idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == sba_pkg::CFG_NODE_BASE) cfg_base = value[BASE_W-1:0];
    else cfg_words = value[POOL_W-1:0];
  endtask

  // Sets both registers, with random unused upper bits on the pool size.
  task automatic set_pool(input logic [BASE_W-1:0] base, input logic [POOL_W-1:0] words);
    logic [CFG_DATA_W-1:0] data;
    wait_idle();
    data = CFG_DATA_W'($urandom);
    data[POOL_W-1:0] = words;
    write_reg(sba_pkg::CFG_NODE_BASE, base);
    write_reg(sba_pkg::CFG_POOL_WORDS, data);
  endtask

  task automatic run_phase(input logic [BASE_W-1:0] base, input logic [POOL_W-1:0] words,
                           input int unsigned count, input int unsigned alloc_pct);
    set_pool(base, words);
    for (int i = 0; i < count; i++) queue_random(alloc_pct);
  endtask

  // Driver: issues queued requests, holds them while busy, idles in random bursts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        grant_expect_q.push_back(predict_request(slot_map, cfg_base, cfg_words, req_i));
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (idle_left != 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (request_q.size() != 0 && !quiet_mode && $urandom_range(0, 5) == 0) begin
        idle_left = $urandom_range(0, 7);
        start <= 1'b0;
      end else if (request_q.size() != 0) begin
        req_i <= request_q.pop_front();
        start <= 1'b1;
        issued_count++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      result_count++;
      if (grant_expect_q.size() == 0) begin
        report_mismatch($sformatf("result with no request waiting: handle %h status %0d",
                                  result_o.granted_handle, result_o.status));
      end else begin
        grant_exp = grant_expect_q.pop_front();
        if (result_o.granted_handle !== grant_exp.granted_handle)
          report_mismatch($sformatf("granted_handle %h, expected %h",
                                    result_o.granted_handle, grant_exp.granted_handle));
        if (result_o.status !== grant_exp.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    result_o.status, grant_exp.status));
      end
    end
  end

  // Guard against a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    req_i      = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    cfg_base   = '0;
    cfg_words  = sba_pkg::POOL_WORDS_RST;
    queued_map = '0;
    slot_map   = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests at the reset settings: first fit, refree and the top slot.
    queue_request(sba_pkg::REQ_ALLOC, 16'h0000);
    queue_request(sba_pkg::REQ_ALLOC, 16'hFFFF);
    queue_request(sba_pkg::REQ_ALLOC, 16'h1234);
    queue_request(sba_pkg::REQ_FREE,  16'h0000);
    queue_request(sba_pkg::REQ_FREE,  16'h00FF);
    queue_request(sba_pkg::REQ_ALLOC, 16'h0000);
    queue_request(sba_pkg::REQ_FREE,  16'hFFFF);
    queue_request(sba_pkg::REQ_FREE,  16'h01AB);
    queue_request(sba_pkg::REQ_ALLOC, 16'h5555);

    // One word with the widest base: handles beyond the pool are rejected.
    set_pool(8'hFF, 3'd1);
    queue_request(sba_pkg::REQ_ALLOC, 16'h0000);
    queue_request(sba_pkg::REQ_FREE,  16'h4000);
    queue_request(sba_pkg::REQ_FREE,  16'hFFFF);
    queue_request(sba_pkg::REQ_FREE,  16'h3F00);

    // An empty pool: allocate reports full and every free a bad handle.
    set_pool(8'h00, 3'd0);
    queue_request(sba_pkg::REQ_ALLOC, 16'h0000);
    queue_request(sba_pkg::REQ_FREE,  16'h0000);

    // An oversized pool setting saturates to the full pool.
    set_pool(8'hA5, 3'd7);
    queue_request(sba_pkg::REQ_ALLOC, 16'hFFFF);
    queue_request(sba_pkg::REQ_FREE,  16'hFF00);
    queue_request(sba_pkg::REQ_FREE,  16'h0300);

    // Random phases: fill small and large pools to full, then drain them again.
    run_phase(8'($urandom_range(0, 255)), 3'd1, 150, 85);
    run_phase(8'hFF, 3'd2, 150, 30);
    run_phase(8'($urandom_range(0, 255)), 3'd0, 20, 50);
    run_phase(8'($urandom_range(0, 255)), 3'd4, 400, 85);
    run_phase(8'($urandom_range(0, 255)), 3'd6, 200, 40);
    run_phase(8'($urandom_range(0, 255)), 3'd5, 60, 50);

    // Last phase runs back to back with no idling.
    set_pool(8'h00, 3'd3);
    quiet_mode = 1'b1;
    for (int i = 0; i < 200; i++) queue_random(60);
    wait_idle();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
